// ===== hw/rtl/bmc_pkg.sv =====
// Shared constants, command/status types and a helper function of the bisymmetric matrix check
package bmc_pkg;

    localparam int MAX_DIM = 8;
    localparam int DIM_W   = $clog2(MAX_DIM);
    localparam int SIZE_W  = 4;
    localparam int DEPTH   = MAX_DIM * MAX_DIM;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int ELEM_W  = 32;
    localparam int RES_W   = 2 * DIM_W + CNT_W;
    localparam int OUT_W   = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W   = OUT_W - RES_W;

    // Read select: which of the four related elements is fetched
    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_DIRECT    = 2'd0;
    localparam t_rd_sel RD_TRANS     = 2'd1;
    localparam t_rd_sel RD_ROT       = 2'd2;
    localparam t_rd_sel RD_ROT_TRANS = 2'd3;

    // Controller to datapath commands
    typedef struct packed {
        logic    load_wr;
        logic    pos_clr;
        logic    pos_adv;
        t_rd_sel rd_sel;
        logic    cap_ref;
        logic    cmp;
        logic    push_pend;
        logic    set_pend;
        logic    flush;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic load_last;
        logic pos_last;
        logic mismatch;
        logic out_free;
        logic pend_valid;
    } t_sts;

    // Clamp the size register to 1..MAX_DIM
    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0] res;
        if (sz == '0) begin
            res = SIZE_W'(1);
        end else if (sz > SIZE_W'(MAX_DIM)) begin
            res = SIZE_W'(MAX_DIM);
        end else begin
            res = sz;
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/bmc_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module bmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/bmc_ctrl.sv =====
// Controller state machine: load sequencing, four-read sweep per position, result hand-off
module bmc_ctrl
    import bmc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [1:0] S_LOAD  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_EMIT  = 2'd2;
    localparam logic [1:0] S_FLUSH = 2'd3;

    localparam logic [2:0] PH_ADDR = 3'd0;
    localparam logic [2:0] PH_REF  = 3'd1;
    localparam logic [2:0] PH_CMP0 = 3'd2;
    localparam logic [2:0] PH_CMP1 = 3'd3;
    localparam logic [2:0] PH_EVAL = 3'd4;

    logic [1:0] r_state, n_state;
    logic [2:0] r_phase, n_phase;

    // Next state and command decode
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_LOAD: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_wr = 1'b1;
                    if (i_sts.load_last) begin
                        o_cmd.pos_clr = 1'b1;
                        n_phase       = PH_ADDR;
                        n_state       = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_sel  = r_phase[1:0];
                o_cmd.cap_ref = (r_phase == PH_REF);
                o_cmd.cmp     = (r_phase == PH_CMP0) || (r_phase == PH_CMP1);
                if (r_phase == PH_EVAL) begin
                    n_phase = PH_ADDR;
                    if (i_sts.mismatch) begin
                        n_state = S_EMIT;
                    end else if (i_sts.pos_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.pos_adv = 1'b1;
                    end
                end else begin
                    n_phase = r_phase + 3'd1;
                end
            end
            S_EMIT: begin
                // Hand the held violation on once the output stage can take it
                if (!i_sts.pend_valid || i_sts.out_free) begin
                    o_cmd.push_pend = i_sts.pend_valid;
                    o_cmd.set_pend  = 1'b1;
                    if (i_sts.pos_last) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.pos_adv = 1'b1;
                        n_state       = S_READ;
                    end
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_phase <= PH_ADDR;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

endmodule

// ===== hw/rtl/bmc_dpath.sv =====
// Datapath: size register, matrix store, position counters, compare, pending and output stages
module bmc_dpath
    import bmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic [ELEM_W-1:0] i_elem,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_m_tvalid,
    output logic              o_m_tuser,
    output logic [OUT_W-1:0]  o_m_tdata,
    output logic              o_m_tlast,
    input  logic              i_m_tready
);

    logic [SIZE_W-1:0] r_size;
    logic [SIZE_W-1:0] n_dim;
    logic [DIM_W-1:0]  dim_m1;
    logic [CNT_W-1:0]  total;
    logic [CNT_W-1:0]  r_load_cnt;
    logic [CNT_W-1:0]  load_inc;
    logic [DIM_W-1:0]  r_row, r_col;
    logic [DIM_W-1:0]  rot_row, rot_col;
    logic [DIM_W-1:0]  rd_r, rd_c;
    logic [ADDR_W-1:0] rd_addr;
    logic [ELEM_W-1:0] rd_q;
    logic [ELEM_W-1:0] r_ref;
    logic              r_mis;
    logic [CNT_W-1:0]  r_viol_cnt;
    logic              r_pend_valid;
    logic [DIM_W-1:0]  r_pend_row, r_pend_col;
    logic [CNT_W-1:0]  r_pend_tot;
    logic              r_out_valid;
    logic              r_out_viol;
    logic              r_out_last;
    logic [DIM_W-1:0]  r_out_row, r_out_col;
    logic [CNT_W-1:0]  r_out_tot;
    logic              out_free;

    // Size decode
    assign n_dim    = eff_size(r_size);
    assign dim_m1   = DIM_W'(n_dim - SIZE_W'(1));
    assign total    = CNT_W'(CNT_W'(n_dim) * CNT_W'(n_dim));
    assign load_inc = r_load_cnt + CNT_W'(1);

    // Mirror indices for the 180-degree rotation
    assign rot_row = dim_m1 - r_row;
    assign rot_col = dim_m1 - r_col;

    // Select the element to fetch for the current position
    always_comb begin
        rd_r = r_row;
        rd_c = r_col;
        unique case (i_cmd.rd_sel)
            RD_DIRECT: begin
                rd_r = r_row;
                rd_c = r_col;
            end
            RD_TRANS: begin
                rd_r = r_col;
                rd_c = r_row;
            end
            RD_ROT: begin
                rd_r = rot_row;
                rd_c = rot_col;
            end
            RD_ROT_TRANS: begin
                rd_r = rot_col;
                rd_c = rot_row;
            end
            default: begin
                rd_r = r_row;
                rd_c = r_col;
            end
        endcase
    end

    assign rd_addr = ADDR_W'(ADDR_W'(rd_r) * ADDR_W'(n_dim) + ADDR_W'(rd_c));

    bmc_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.load_wr),
        .i_waddr (r_load_cnt[ADDR_W-1:0]),
        .i_wdata (i_elem),
        .i_raddr (rd_addr),
        .o_rdata (rd_q)
    );

    // Size register and load counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= SIZE_W'(MAX_DIM);
            r_load_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                r_size     <= i_cfg_data;
                r_load_cnt <= '0;
            end else if (i_cmd.load_wr) begin
                r_load_cnt <= (load_inc == total) ? '0 : load_inc;
            end
        end
    end

    // Position counters, row-major sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.pos_clr) begin
            r_row <= '0;
            r_col <= '0;
        end else if (i_cmd.pos_adv) begin
            if (r_col == dim_m1) begin
                r_col <= '0;
                r_row <= r_row + DIM_W'(1);
            end else begin
                r_col <= r_col + DIM_W'(1);
            end
        end
    end

    // Hold the first element and accumulate mismatches against it
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_ref) begin
            r_ref <= rd_q;
            r_mis <= 1'b0;
        end else if (i_cmd.cmp) begin
            r_mis <= r_mis | (rd_q != r_ref);
        end
    end

    // Violation counter and the held violation, which waits to learn if it is the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_viol_cnt   <= '0;
            r_pend_valid <= 1'b0;
        end else begin
            if (i_cfg_we || i_cmd.flush) begin
                r_viol_cnt   <= '0;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.set_pend) begin
                r_viol_cnt   <= r_viol_cnt + CNT_W'(1);
                r_pend_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_pend) begin
            r_pend_row <= r_row;
            r_pend_col <= r_col;
            r_pend_tot <= r_viol_cnt + CNT_W'(1);
        end
    end

    assign out_free = !r_out_valid || i_m_tready;

    // Output stage: valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push_pend || i_cmd.flush) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output stage: payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_pend) begin
            r_out_viol <= 1'b1;
            r_out_last <= 1'b0;
            r_out_row  <= r_pend_row;
            r_out_col  <= r_pend_col;
            r_out_tot  <= r_pend_tot;
        end else if (i_cmd.flush) begin
            r_out_last <= 1'b1;
            if (r_pend_valid) begin
                r_out_viol <= 1'b1;
                r_out_row  <= r_pend_row;
                r_out_col  <= r_pend_col;
                r_out_tot  <= r_pend_tot;
            end else begin
                r_out_viol <= 1'b0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_tot  <= '0;
            end
        end
    end

    // Status to the controller
    assign o_sts.load_last  = (load_inc == total);
    assign o_sts.pos_last   = (r_row == dim_m1) && (r_col == dim_m1);
    assign o_sts.mismatch   = r_mis | (rd_q != r_ref);
    assign o_sts.out_free   = out_free;
    assign o_sts.pend_valid = r_pend_valid;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_viol;
    assign o_m_tdata  = {{PAD_W{1'b0}}, r_out_tot, r_out_col, r_out_row};
    assign o_m_tlast  = r_out_last;

endmodule

// ===== hw/rtl/bisymmetric_matrix_check.sv =====
// Top level of the bisymmetric matrix check: controller plus datapath
//
//  Channel   Dir  Payload                                       Transfer
//  s_axis    in   tdata[31:0] element_value                     tvalid & tready
//  m_axis    out  tdata[12:0] row, column, total; tuser flag;   tvalid & tready
//                 tlast final result
//  cfg       in   i_cfg_data[3:0] size_in_use                   i_cfg_we
//
// Loading takes one element per cycle while s_axis_tready is high.
// After the last element the sweep reads four elements per position through the single
// read port of the store, takes an extra step for each violation and closes with a flush.
// s_axis_tready stays low during the sweep and while a result waits for the output stage.
// Reset is synchronous, active low; the store is not cleared.
module bisymmetric_matrix_check
    import bmc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Configuration
    input  logic                     i_cfg_we,
    input  logic [SIZE_W-1:0]        i_cfg_data,
    // Element stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic signed [ELEM_W-1:0] s_axis_tdata,   // [31:0] element_value
    // Result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_W-1:0]         m_axis_tdata,   // [2:0] row_index, [5:3] column_index,
                                                     // [12:6] violation_total, [15:13] zero
    output logic                     m_axis_tuser,   // [0] is_violation
    output logic                     m_axis_tlast
);

    t_cmd cmd;
    t_sts sts;

    bmc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bmc_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_elem     (s_axis_tdata),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tuser  (m_axis_tuser),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast),
        .i_m_tready (m_axis_tready)
    );

endmodule

// ===== hw/rtl/bmc_checker.sv =====
// Port-level assertions for the bisymmetric matrix check, bound to the top level
module bmc_checker
    import bmc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,
    input logic             m_axis_tuser,
    input logic             m_axis_tlast
);

    // No result straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A clean summary is the only result and carries zeros
    a_clean_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
        else $error("clean result not final or not zero");

    // A violation result counts itself and never exceeds the store size
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata[RES_W-1:2*DIM_W] != '0) &&
            (m_axis_tdata[RES_W-1:2*DIM_W] <= CNT_W'(DEPTH)))
        else $error("violation total out of range");

    // After a non-final violation transfer the next result counts one more
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser && !m_axis_tlast ##1 m_axis_tvalid
        |-> m_axis_tuser &&
            (m_axis_tdata[RES_W-1:2*DIM_W] ==
             $past(m_axis_tdata[RES_W-1:2*DIM_W]) + CNT_W'(1)))
        else $error("violation total did not advance by one");

    // A stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind bisymmetric_matrix_check bmc_checker u_bmc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/bisymmetric_matrix_check_test.sv =====
// Self-checking testbench for the bisymmetric matrix check: stream stimulus, prediction, scoreboard
`timescale 1ns / 1ps

module bisymmetric_matrix_check_test;
    import bmc_pkg::*;

    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_ITEMS  = 450;

    typedef struct {
        logic signed [ELEM_W-1:0] value;
        int unsigned              gap;
    } elem_xfer_t;

    typedef struct packed {
        logic             flag;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [CNT_W-1:0] total;
        logic             last;
    } check_report_t;

    typedef enum int {SHAPE_BISYM, SHAPE_FLAWED, SHAPE_RANDOM} matrix_shape_t;

    // DUT connections
    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     i_cfg_we      = 1'b0;
    logic [SIZE_W-1:0]        i_cfg_data    = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic signed [ELEM_W-1:0] s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_W-1:0]         m_axis_tdata;
    logic                     m_axis_tuser;
    logic                     m_axis_tlast;

    // Stimulus and scoreboard state
    elem_xfer_t               element_q[$];
    check_report_t            pending_reports[$];
    elem_xfer_t               staged;
    bit                       staged_ok   = 1'b0;
    int unsigned              gap_left    = 0;
    bit                       tx_steady   = 1'b0;
    bit                       rx_steady   = 1'b0;
    logic                     hold_start  = 1'b0;
    int unsigned              hold_left   = 0;
    int unsigned              stall_left  = 0;

    // Predictor copy of the block state
    logic signed [ELEM_W-1:0] stored_elems [DEPTH];
    logic [SIZE_W-1:0]        size_reg    = SIZE_W'(MAX_DIM);
    int unsigned              loaded      = 0;

    // Run statistics
    int unsigned              fail_count        = 0;
    int unsigned              items_queued      = 0;
    int unsigned              elements_accepted = 0;
    int unsigned              matrices_checked  = 0;
    int unsigned              results_seen      = 0;
    int unsigned              violations_seen   = 0;
    logic [15:0]              sizes_written     = '0;

    bisymmetric_matrix_check u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Guard against a hung run
    initial begin
        #5_000_000;
        $display("Timeout waiting for the block to drain");
        $display("Simulation FAILED");
        $finish;
    end

    // Clamp a size code to the dimension actually used
    function automatic int active_dim(logic [SIZE_W-1:0] code);
        if (code == '0) return 1;
        if (int'(code) > MAX_DIM) return MAX_DIM;
        return int'(code);
    endfunction

    function automatic void note_failure(string msg);
        fail_count++;
        if (fail_count <= 10) $display("%0t ns mismatch: %s", $realtime, msg);
    endfunction

    // Store one element; on the last one sweep the matrix and queue the reports it yields
    function automatic void record_element(logic signed [ELEM_W-1:0] v);
        int                       n;
        int                       r;
        int                       c;
        int unsigned              hits;
        logic signed [ELEM_W-1:0] a;
        logic signed [ELEM_W-1:0] b;
        logic signed [ELEM_W-1:0] d;
        logic signed [ELEM_W-1:0] e;
        check_report_t            rep;
        n = active_dim(size_reg);
        stored_elems[loaded % DEPTH] = v;
        loaded++;
        if (loaded < n * n) return;
        hits = 0;
        for (r = 0; r < n; r++) begin
            for (c = 0; c < n; c++) begin
                a = stored_elems[r * n + c];
                b = stored_elems[c * n + r];
                d = stored_elems[(n - 1 - r) * n + (n - 1 - c)];
                e = stored_elems[(n - 1 - c) * n + (n - 1 - r)];
                if (a != b || a != d || d != e || b != e) begin
                    hits++;
                    rep.flag  = 1'b1;
                    rep.row   = DIM_W'(r);
                    rep.col   = DIM_W'(c);
                    rep.total = CNT_W'(hits);
                    rep.last  = 1'b0;
                    pending_reports.push_back(rep);
                end
            end
        end
        if (hits == 0) begin
            rep = '{flag: 1'b0, row: '0, col: '0, total: '0, last: 1'b1};
            pending_reports.push_back(rep);
        end else begin
            pending_reports[pending_reports.size() - 1].last = 1'b1;
        end
        loaded = 0;
        matrices_checked++;
    endfunction

    // Element driver: pop pending transfers, wait out each gap, hold tvalid until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            staged_ok = 1'b0;
            gap_left  = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                record_element(s_axis_tdata);
                elements_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (!staged_ok && element_q.size() > 0) begin
                    staged    = element_q.pop_front();
                    staged_ok = 1'b1;
                    gap_left  = staged.gap;
                end
                if (staged_ok && gap_left == 0) begin
                    s_axis_tdata  <= staged.value;
                    s_axis_tvalid <= 1'b1;
                    staged_ok = 1'b0;
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (staged_ok) gap_left--;
                end
            end
        end
    end

    // Long output hold-off, counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (hold_start) begin
            hold_left <= HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor: compare each transfer with the oldest expected report, then stall at random unless rx_steady
    always @(posedge i_clk) begin
        check_report_t want;
        check_report_t got;
        int unsigned   stall_next;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end else begin
            stall_next = (stall_left > 0) ? stall_left - 1 : 0;
            if (m_axis_tvalid && m_axis_tready) begin
                got.flag  = m_axis_tuser;
                got.row   = m_axis_tdata[DIM_W-1:0];
                got.col   = m_axis_tdata[2*DIM_W-1:DIM_W];
                got.total = m_axis_tdata[2*DIM_W+CNT_W-1:2*DIM_W];
                got.last  = m_axis_tlast;
                results_seen++;
                if (got.flag) violations_seen++;
                if (pending_reports.size() == 0) begin
                    note_failure($sformatf("unexpected result flag=%0b row=%0d col=%0d total=%0d last=%0b",
                                           got.flag, got.row, got.col, got.total, got.last));
                end else begin
                    want = pending_reports.pop_front();
                    if (got.flag !== want.flag || got.row !== want.row || got.col !== want.col ||
                        got.total !== want.total || got.last !== want.last) begin
                        note_failure($sformatf({"expected flag=%0b row=%0d col=%0d total=%0d last=%0b,",
                                                " got flag=%0b row=%0d col=%0d total=%0d last=%0b"},
                                               want.flag, want.row, want.col, want.total, want.last,
                                               got.flag, got.row, got.col, got.total, got.last));
                    end
                end
                stall_next = rx_steady ? 0 : $urandom_range(0, 8);
            end
            stall_left    <= stall_next;
            m_axis_tready <= (stall_next == 0) && (hold_left == 0);
        end
    end

    function automatic logic signed [ELEM_W-1:0] draw_element();
        case ($urandom_range(0, 7))
            0:       return {1'b1, {(ELEM_W-1){1'b0}}};
            1:       return {1'b0, {(ELEM_W-1){1'b1}}};
            2, 3, 4: return ELEM_W'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    function automatic void push_element(logic signed [ELEM_W-1:0] v);
        elem_xfer_t x;
        x.value = v;
        x.gap   = tx_steady ? 0 : $urandom_range(0, 8);
        element_q.push_back(x);
        items_queued++;
    endfunction

    // Build one n x n matrix; bisymmetric shapes copy each element from its orbit's first member
    function automatic void queue_matrix(int n, matrix_shape_t shape);
        logic signed [ELEM_W-1:0] grid [DEPTH];
        int p;
        int q;
        int r;
        int c;
        int pos;
        for (p = 0; p < n * n; p++) begin
            r = p / n;
            c = p % n;
            q = p;
            if (c * n + r < q) q = c * n + r;
            if ((n - 1 - r) * n + (n - 1 - c) < q) q = (n - 1 - r) * n + (n - 1 - c);
            if ((n - 1 - c) * n + (n - 1 - r) < q) q = (n - 1 - c) * n + (n - 1 - r);
            if (shape == SHAPE_RANDOM || q == p) grid[p] = draw_element();
            else grid[p] = grid[q];
        end
        if (shape == SHAPE_FLAWED) begin
            repeat ($urandom_range(1, 2)) begin
                pos = $urandom_range(0, n * n - 1);
                grid[pos] = grid[pos] ^ (ELEM_W'(1) << $urandom_range(0, ELEM_W - 1));
            end
        end
        for (p = 0; p < n * n; p++) push_element(grid[p]);
    endfunction

    // Write the size register while the block is idle and mirror it in the predictor
    task automatic set_size(logic [SIZE_W-1:0] code);
        @(posedge i_clk);
        i_cfg_data <= code;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        size_reg = code;
        loaded   = 0;
        sizes_written[code] = 1'b1;
        @(negedge i_clk);
    endtask

    // Hold until every queued element is accepted and every report has arrived, then let it settle
    task automatic settle_idle();
        do @(negedge i_clk);
        while (element_q.size() != 0 || staged_ok || s_axis_tvalid || pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic pulse_hold();
        @(posedge i_clk);
        hold_start <= 1'b1;
        @(posedge i_clk);
        hold_start <= 1'b0;
        @(negedge i_clk);
    endtask

    // Main sequence
    initial begin
        logic [SIZE_W-1:0] code;
        int                n;
        int                phase;
        int                pick;
        matrix_shape_t     shape;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset size: one flawed full-size matrix
        queue_matrix(MAX_DIM, SHAPE_FLAWED);
        settle_idle();

        // Size code zero acts as one: extreme values give clean single-element checks
        set_size('0);
        push_element({1'b1, {(ELEM_W-1){1'b0}}});
        push_element({1'b0, {(ELEM_W-1){1'b1}}});
        settle_idle();

        // Two by two: one bisymmetric, one not
        set_size(SIZE_W'(2));
        push_element({1'b1, {(ELEM_W-1){1'b0}}});
        push_element({1'b0, {(ELEM_W-1){1'b1}}});
        push_element({1'b0, {(ELEM_W-1){1'b1}}});
        push_element({1'b1, {(ELEM_W-1){1'b0}}});
        push_element({1'b0, {(ELEM_W-1){1'b1}}});
        push_element({1'b1, {(ELEM_W-1){1'b0}}});
        push_element({1'b1, {(ELEM_W-1){1'b0}}});
        push_element('0);
        settle_idle();

        // Three by three, all distinct: every position but the centre fails
        set_size(SIZE_W'(3));
        for (int k = 0; k < 9; k++) push_element(ELEM_W'(k * 7 - 20));
        settle_idle();

        // Size write in the middle of loading restarts the matrix
        for (int k = 0; k < 4; k++) push_element(ELEM_W'(k));
        settle_idle();
        set_size(SIZE_W'(1));
        push_element('1);
        settle_idle();

        // Clamped size code, full width
        set_size('1);
        queue_matrix(MAX_DIM, SHAPE_BISYM);
        settle_idle();

        // Random phases
        phase = 0;
        while (items_queued < RANDOM_ITEMS + 24) begin
            tx_steady = ($urandom_range(0, 3) == 0);
            rx_steady = ($urandom_range(0, 3) == 0);
            if (phase == 5) begin
                // Stall the output long enough that the block backs up into its input
                tx_steady = 1'b1;
                set_size(SIZE_W'(2));
                pulse_hold();
                repeat (6) queue_matrix(2, ($urandom_range(0, 1) == 0) ? SHAPE_BISYM : SHAPE_FLAWED);
            end else begin
                pick = $urandom_range(0, 19);
                if (pick < 14)       code = SIZE_W'($urandom_range(1, 4));
                else if (pick < 16)  code = SIZE_W'($urandom_range(5, 7));
                else if (pick == 16) code = SIZE_W'(MAX_DIM);
                else if (pick == 17) code = SIZE_W'($urandom_range(MAX_DIM + 1, 15));
                else                 code = '0;
                if (pick != 19 || phase == 0) set_size(code);
                n = active_dim(size_reg);
                repeat ((n >= 5) ? 1 : $urandom_range(1, 4)) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 4)      shape = SHAPE_BISYM;
                    else if (pick < 8) shape = SHAPE_FLAWED;
                    else               shape = SHAPE_RANDOM;
                    queue_matrix(n, shape);
                end
            end
            settle_idle();
            phase++;
        end

        $display("Checked %0d matrices from %0d elements in %0d phases; %0d results, %0d violations.",
                 matrices_checked, elements_accepted, phase, results_seen, violations_seen);
        $display("Size codes written (bit mask): %04h; one long output hold-off; %0d mismatches.",
                 sizes_written, fail_count);
        if (fail_count == 0 && pending_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/bmc_pkg.sv
hw/rtl/bmc_ram.sv
hw/rtl/bmc_ctrl.sv
hw/rtl/bmc_dpath.sv
hw/rtl/bisymmetric_matrix_check.sv
hw/rtl/bmc_checker.sv
bench/bisymmetric_matrix_check_test.sv
